// ===== rtl/rotate_xor_block_hash_core_macros.svh =====
// assertion macros for the rotate-xor block hash core
// used by the top level, expects aclk and aresetn in scope
`ifndef ROTATE_XOR_BLOCK_HASH_CORE_MACROS_SVH
`define ROTATE_XOR_BLOCK_HASH_CORE_MACROS_SVH

// same-cycle implication
`define RXBH_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RXBH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// condition that must never hold
`define RXBH_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/rxbh_pkg.sv =====
// package for the rotate-xor block hash core
// sizes, queue entry and status types; no dependencies
`timescale 1ns / 1ps

package rxbh_pkg;

    localparam int BLOCK_BYTES   = 16;
    localparam int LENGTH_DIGITS = 5;
    localparam int QUEUE_DEPTH   = 4;

    localparam int HASH_W  = 8 * BLOCK_BYTES;
    localparam int FILL_W  = $clog2(BLOCK_BYTES);
    localparam int BCD_W   = 4 * LENGTH_DIGITS;
    localparam int DIG_W   = $clog2(LENGTH_DIGITS + 1);
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int INDEX_W = 4;

    // fill level at which the zero run ends so the digits close the last block
    localparam int PAD_STOP = (BLOCK_BYTES - (LENGTH_DIGITS % BLOCK_BYTES)) % BLOCK_BYTES;

    localparam logic [7:0] ASCII_ZERO = 8'h30;

    typedef struct packed {
        logic [7:0] data;
        logic       end_mark;
        logic       sat;
    } rxbh_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } rxbh_fifo_stat_t;

endpackage

// ===== rtl/rxbh_fifo.sv =====
// small queue between the front and back parts of the hash core
// depends on rxbh_pkg
`timescale 1ns / 1ps

module rxbh_fifo
    import rxbh_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  rxbh_entry_t     push_entry,
    input  logic            pop,
    output rxbh_entry_t     pop_entry,
    output rxbh_fifo_stat_t stat
);

    rxbh_entry_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_entry  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/rxbh_front.sv =====
// front part: accepts message bytes, counts length in bcd, emits padding
// depends on rxbh_pkg
`timescale 1ns / 1ps

module rxbh_front
    import rxbh_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,
    input  logic            s_tlast,
    input  rxbh_fifo_stat_t q_stat,
    output logic            q_push,
    output rxbh_entry_t     q_entry
);

    typedef enum logic [2:0] {
        FR_IDLE  = 3'b001,
        FR_PAD   = 3'b010,
        FR_DIGIT = 3'b100
    } fr_state_t;

    fr_state_t          state_reg, state_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic               sat_reg, sat_next;
    logic [FILL_W-1:0]  fill_reg, fill_next, fill_inc;
    logic [DIG_W-1:0]   dig_cnt_reg, dig_cnt_next;
    logic [DIG_W-1:0]   dig_sel;
    logic               bcd_full;

    function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] r;
        logic             carry;
        r     = v;
        carry = 1'b1;
        for (int i = 0; i < LENGTH_DIGITS; i++) begin
            if (carry) begin
                if (v[4*i +: 4] == 4'd9) begin
                    r[4*i +: 4] = 4'd0;
                end else begin
                    r[4*i +: 4] = v[4*i +: 4] + 4'd1;
                    carry       = 1'b0;
                end
            end
        end
        return r;
    endfunction

    always_comb begin
        bcd_full = 1'b1;
        for (int i = 0; i < LENGTH_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] != 4'd9) begin
                bcd_full = 1'b0;
            end
        end
    end

    assign fill_inc = (fill_reg == FILL_W'(BLOCK_BYTES - 1)) ? '0 : fill_reg + 1'b1;
    assign dig_sel  = DIG_W'(LENGTH_DIGITS - 1) - dig_cnt_reg;
    assign s_tready = (state_reg == FR_IDLE) && !q_stat.full;

    always_comb begin
        state_next       = state_reg;
        bcd_next         = bcd_reg;
        sat_next         = sat_reg;
        fill_next        = fill_reg;
        dig_cnt_next     = dig_cnt_reg;
        q_push           = 1'b0;
        q_entry.data     = s_tdata;
        q_entry.end_mark = 1'b0;
        q_entry.sat      = sat_reg;
        unique case (state_reg)
            FR_IDLE: begin
                if (s_tvalid && s_tready) begin
                    q_push    = 1'b1;
                    fill_next = fill_inc;
                    if (bcd_full) begin
                        sat_next = 1'b1;
                    end else begin
                        bcd_next = bcd_inc(bcd_reg);
                    end
                    if (s_tlast) begin
                        state_next = FR_PAD;
                    end
                end
            end
            FR_PAD: begin
                q_entry.data = ASCII_ZERO;
                if (!q_stat.full) begin
                    q_push    = 1'b1;
                    fill_next = fill_inc;
                    if (fill_inc == FILL_W'(PAD_STOP)) begin
                        state_next   = FR_DIGIT;
                        dig_cnt_next = '0;
                    end
                end
            end
            FR_DIGIT: begin
                q_entry.data     = ASCII_ZERO | {4'd0, bcd_reg[4*dig_sel +: 4]};
                q_entry.end_mark = (dig_cnt_reg == DIG_W'(LENGTH_DIGITS - 1));
                if (!q_stat.full) begin
                    q_push       = 1'b1;
                    fill_next    = fill_inc;
                    dig_cnt_next = dig_cnt_reg + 1'b1;
                    if (q_entry.end_mark) begin
                        state_next = FR_IDLE;
                        bcd_next   = '0;
                        sat_next   = 1'b0;
                    end
                end
            end
            default: begin
                state_next = FR_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FR_IDLE;
            bcd_reg     <= '0;
            sat_reg     <= 1'b0;
            fill_reg    <= '0;
            dig_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            bcd_reg     <= bcd_next;
            sat_reg     <= sat_next;
            fill_reg    <= fill_next;
            dig_cnt_reg <= dig_cnt_next;
        end
    end

endmodule

// ===== rtl/rxbh_back.sv =====
// back part: buffers blocks, folds them into the hash, emits hash bytes
// depends on rxbh_pkg
`timescale 1ns / 1ps

module rxbh_back
    import rxbh_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  rxbh_fifo_stat_t q_stat,
    input  rxbh_entry_t     q_entry,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [15:0]     m_tdata,
    output logic            m_tlast,
    output logic            m_tuser
);

    typedef enum logic [1:0] {
        BK_ABSORB = 2'b01,
        BK_EMIT   = 2'b10
    } bk_state_t;

    bk_state_t          state_reg, state_next;
    logic [7:0]         blk_reg [BLOCK_BYTES];
    logic [HASH_W-1:0]  hash_reg, hash_next;
    logic [HASH_W-1:0]  block_vec;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [FILL_W-1:0]  out_cnt_reg, out_cnt_next;
    logic               sat_reg, sat_next;
    logic               block_done;

    // most significant byte of the block is entry zero
    always_comb begin
        for (int k = 0; k < BLOCK_BYTES - 1; k++) begin
            block_vec[8*(BLOCK_BYTES-1-k) +: 8] = blk_reg[k];
        end
        block_vec[7:0] = q_entry.data;
    end

    assign q_pop      = (state_reg == BK_ABSORB) && !q_stat.empty;
    assign block_done = (fill_reg == FILL_W'(BLOCK_BYTES - 1));

    always_comb begin
        state_next   = state_reg;
        hash_next    = hash_reg;
        fill_next    = fill_reg;
        out_cnt_next = out_cnt_reg;
        sat_next     = sat_reg;
        unique case (state_reg)
            BK_ABSORB: begin
                if (q_pop) begin
                    if (block_done) begin
                        hash_next = {hash_reg[HASH_W-2:0], hash_reg[HASH_W-1]} ^ block_vec;
                        fill_next = '0;
                    end else begin
                        fill_next = fill_reg + 1'b1;
                    end
                    if (q_entry.end_mark) begin
                        state_next   = BK_EMIT;
                        sat_next     = q_entry.sat;
                        out_cnt_next = '0;
                    end
                end
            end
            BK_EMIT: begin
                if (m_tready) begin
                    // shifting out all bytes leaves the hash cleared
                    hash_next    = {hash_reg[HASH_W-9:0], 8'd0};
                    out_cnt_next = out_cnt_reg + 1'b1;
                    if (out_cnt_reg == FILL_W'(BLOCK_BYTES - 1)) begin
                        state_next = BK_ABSORB;
                    end
                end
            end
            default: begin
                state_next = BK_ABSORB;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_ABSORB;
            hash_reg    <= '0;
            fill_reg    <= '0;
            out_cnt_reg <= '0;
            sat_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            hash_reg    <= hash_next;
            fill_reg    <= fill_next;
            out_cnt_reg <= out_cnt_next;
            sat_reg     <= sat_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            blk_reg[fill_reg] <= q_entry.data;
        end
    end

    assign m_tvalid = (state_reg == BK_EMIT);
    assign m_tdata  = {4'd0, INDEX_W'(out_cnt_reg), hash_reg[HASH_W-1 -: 8]};
    assign m_tlast  = (out_cnt_reg == FILL_W'(BLOCK_BYTES - 1));
    assign m_tuser  = sat_reg;

endmodule

// ===== rtl/rotate_xor_block_hash_core.sv =====
// top level of the rotate-xor block hash core
// depends on rxbh_pkg, rxbh_front, rxbh_fifo, rxbh_back and the macros header
`timescale 1ns / 1ps

// rotate-xor block hash: message bytes stream in on the s_ side, one per
// transaction, and are gathered into 16-byte blocks; each full block rotates
// the 128-bit hash left by one bit and is xored in. the transaction with tlast
// closes the message: the front pads it with 1 to 16 ascii '0' bytes and the
// length as five ascii decimal digits (clamped at 99999, which sets tuser on
// the output), then the 16 hash bytes leave on the m_ side, most significant
// first, and the core is ready for the next message with the hash at zero.
// rate: one message byte per cycle while streaming and the queue has room.
// after the last byte the front pushes the padding bytes into the queue (6 to 21
// of them, one queue push each) before it takes the next message; every push
// waits while the queue is full, which happens when the back is still
// emitting the previous hash. the back drains the same bytes at one per cycle
// and then shows the 16 hash bytes at one per cycle as m_tready allows. a
// 4-entry queue between front and back lets the next message's first bytes
// enter while the hash of the previous one is emitted.

module rotate_xor_block_hash_core
    import rxbh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] hash_byte, [11:8] byte_index, [15:12] zero
    output logic        m_tlast,   // final_byte
    output logic        m_tuser    // [0] length_saturated
);

`include "rotate_xor_block_hash_core_macros.svh"

    rxbh_fifo_stat_t fifo_stat;
    rxbh_entry_t     push_entry;
    rxbh_entry_t     pop_entry;
    logic            push;
    logic            pop;

    // front: takes bytes, tracks length, generates the padding stream
    rxbh_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_stat   (fifo_stat),
        .q_push   (push),
        .q_entry  (push_entry)
    );

    // queue decoupling the two sides
    rxbh_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .stat       (fifo_stat)
    );

    // back: block buffer, fold, hash emission
    rxbh_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (fifo_stat),
        .q_entry  (pop_entry),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // the back must absorb a whole padded block before the next hash appears
    `RXBH_ASSERT_NEXT(a_gap_after_hash, m_tvalid && m_tready && m_tlast, !m_tvalid, "hash run not followed by gap")
    // the front stops taking bytes while it pads
    `RXBH_ASSERT_NEXT(a_pad_blocks_input, s_tvalid && s_tready && s_tlast, !s_tready, "input taken during padding")
    // final mark sits on the last index of the run
    `RXBH_ASSERT_SAME(a_final_index, m_tvalid, m_tlast == (m_tdata[11:8] == 4'(BLOCK_BYTES - 1)), "final mark at wrong index")
    // queue status stays consistent
    `RXBH_ASSERT_NEVER(a_fifo_stat, fifo_stat.full && fifo_stat.empty, "queue full and empty at once")

endmodule

// ===== dv/rotate_xor_block_hash_core_tb.sv =====
// self-checking testbench for rotate_xor_block_hash_core
// depends on rxbh_pkg and the core; a built-in predictor works out every hash byte
`timescale 1ns / 1ps

module rotate_xor_block_hash_core_tb;
    import rxbh_pkg::*;

    localparam int          HALF_PERIOD = 4;
    localparam int unsigned LEN_LIMIT   = 10 ** LENGTH_DIGITS - 1;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int          RANDOM_ITEMS = 440;
    localparam int          DRAIN_CYCLES = 64;

    // one message byte waiting to be driven, with the idle cycles before it
    typedef struct {
        logic [7:0]  data;
        logic        last;
        int unsigned gap;
    } msg_item_t;

    // one hash byte as it should leave the core
    typedef struct {
        logic [7:0] hash;
        logic [3:0] idx;
        logic       fin;
        logic       sat;
    } hash_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    // stimulus and scoreboard
    msg_item_t    message_bytes[$];
    hash_result_t pending_hash_bytes[$];
    int unsigned  mismatch_count = 0;
    int unsigned  cycle_count    = 0;

    // predictor state: running digest, partial block, length counter
    logic [HASH_W-1:0] digest;
    logic [7:0]        blk [BLOCK_BYTES];
    int unsigned       blk_fill;
    int unsigned       msg_len;
    logic              len_clamped;

    // driver state
    msg_item_t   staged;
    msg_item_t   next_item;
    logic        have_staged = 1'b0;
    logic        launch;
    int unsigned gap_left    = 0;

    // sink backpressure state
    int unsigned stall_left     = 0;
    int unsigned sink_calm_left = 0;

    rotate_xor_block_hash_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #HALF_PERIOD aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // mostly short idle stretches, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // buffer one byte of the padded message; a full block rotates the
    // digest left by one bit (top bit wraps around) and is xored in
    task automatic push_padded_byte(input logic [7:0] b);
        logic [HASH_W-1:0] block_word;
        int                k;
        blk[blk_fill] = b;
        blk_fill++;
        if (blk_fill == BLOCK_BYTES) begin
            for (k = 0; k < BLOCK_BYTES; k++)
                block_word[HASH_W-1-8*k -: 8] = blk[k];
            digest   = {digest[HASH_W-2:0], digest[HASH_W-1]} ^ block_word;
            blk_fill = 0;
        end
    endtask

    // account for one accepted message byte; a closing byte pads the message
    // and queues the 16 hash bytes it produces
    task automatic absorb_message_byte(input logic [7:0] data, input logic last);
        int unsigned  pad_zeros;
        int unsigned  len;
        logic [7:0]   digits [LENGTH_DIGITS];
        hash_result_t r;
        int           k;
        // the count sticks at the limit and remembers that it did
        if (msg_len >= LEN_LIMIT) begin
            msg_len     = LEN_LIMIT;
            len_clamped = 1'b1;
        end else begin
            msg_len++;
        end
        push_padded_byte(data);
        if (!last)
            return;
        // zero run follows the true fill, so the digits close the last block
        pad_zeros = BLOCK_BYTES - ((blk_fill + LENGTH_DIGITS) % BLOCK_BYTES);
        repeat (pad_zeros) push_padded_byte(ASCII_ZERO);
        len = msg_len;
        for (k = LENGTH_DIGITS - 1; k >= 0; k--) begin
            digits[k] = ASCII_ZERO + 8'(len % 10);
            len       = len / 10;
        end
        for (k = 0; k < LENGTH_DIGITS; k++)
            push_padded_byte(digits[k]);
        for (k = 0; k < BLOCK_BYTES; k++) begin
            r.hash = digest[HASH_W-1-8*k -: 8];
            r.idx  = 4'(k);
            r.fin  = (k == BLOCK_BYTES - 1);
            r.sat  = len_clamped;
            pending_hash_bytes.push_back(r);
        end
        digest      = '0;
        blk_fill    = 0;
        msg_len     = 0;
        len_clamped = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    task automatic add_item(input logic [7:0] data, input logic last, input int unsigned gap);
        msg_item_t it;
        it.data = data;
        it.last = last;
        it.gap  = gap;
        message_bytes.push_back(it);
    endtask

    // message of random bytes; a burst message is sent back to back
    task automatic add_random_message(input int unsigned len, input bit burst);
        int unsigned i;
        for (i = 0; i < len; i++)
            add_item(8'($urandom_range(0, 255)), i == len - 1, burst ? 0 : idle_len());
    endtask

    // ---------------------------------------------------------------
    // driver: presents queued message bytes, holds each until accepted
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            // the transaction that completes at this edge goes to the predictor
            if (s_tvalid)
                absorb_message_byte(s_tdata, s_tlast);
            launch = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (have_staged) begin
                next_item   = staged;
                have_staged = 1'b0;
                launch      = 1'b1;
            end else if (message_bytes.size() > 0) begin
                next_item = message_bytes.pop_front();
                if (next_item.gap > 0) begin
                    // idle now and until gap_left runs out, then send it
                    staged      = next_item;
                    have_staged = 1'b1;
                    gap_left    = next_item.gap - 1;
                end else begin
                    launch = 1'b1;
                end
            end
            s_tvalid <= launch;
            if (launch) begin
                s_tdata <= next_item.data;
                s_tlast <= next_item.last;
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: checks each hash transaction, drives random backpressure
    // ---------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        hash_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_hash_bytes.size() == 0) begin
                    $display("%0t: unexpected hash transaction, expected none, actual tdata 0x%0h",
                             $time, m_tdata);
                    mismatch_count++;
                end else begin
                    want = pending_hash_bytes.pop_front();
                    check_field("hash_byte", want.hash, m_tdata[7:0]);
                    check_field("byte_index", want.idx, m_tdata[11:8]);
                    check_field("tdata padding", 0, m_tdata[15:12]);
                    check_field("final_byte", want.fin, m_tlast);
                    check_field("length_saturated", want.sat, m_tuser);
                end
            end
            // stalls start at random except in calm stretches
            if (stall_left == 0 && sink_calm_left == 0 && $urandom_range(0, 3) == 0)
                stall_left = idle_len() + 1;
            if (sink_calm_left > 0)
                sink_calm_left--;
            else if ($urandom_range(0, 199) == 0)
                sink_calm_left = $urandom_range(50, 400);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus and end of run
    // ---------------------------------------------------------------
    initial begin
        int unsigned random_count;
        int unsigned len;
        int unsigned r;

        digest      = '0;
        blk_fill    = 0;
        msg_len     = 0;
        len_clamped = 1'b0;

        // shortest messages, extreme byte values
        add_item(8'h00, 1'b1, 0);
        add_item(8'hFF, 1'b1, idle_len());
        // eleven bytes: longest zero run, two blocks so the top bit wraps
        add_item(8'hFF, 1'b0, 0);
        add_item(8'h80, 1'b0, 0);
        add_item(8'h01, 1'b0, 1);
        add_item(8'h7F, 1'b0, 0);
        add_item(8'hAA, 1'b0, 0);
        add_item(8'h55, 1'b0, 2);
        add_item(8'hFE, 1'b0, 0);
        add_item(8'h00, 1'b0, 0);
        add_item(8'hFF, 1'b0, 0);
        add_item(8'h30, 1'b0, 0);
        add_item(8'h39, 1'b1, 0);
        // ten bytes: a single padding zero
        add_random_message(10, 1'b0);

        // random messages, mostly short, some bursts with no idling
        random_count = 0;
        while (random_count < RANDOM_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r < 6)
                len = $urandom_range(1, 20);
            else if (r < 9)
                len = $urandom_range(21, 48);
            else
                len = $urandom_range(49, 80);
            add_random_message(len, $urandom_range(0, 4) == 0);
            random_count += len;
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // every byte sent, every hash byte seen, then a quiet tail
        while (message_bytes.size() > 0 || have_staged || s_tvalid ||
               pending_hash_bytes.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (pending_hash_bytes.size() != 0) begin
            $display("%0t: %0d hash bytes never arrived", $time, pending_hash_bytes.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge aclk);
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rxbh_pkg.sv
rtl/rxbh_fifo.sv
rtl/rxbh_front.sv
rtl/rxbh_back.sv
rtl/rotate_xor_block_hash_core.sv
dv/rotate_xor_block_hash_core_tb.sv
